// ===== sv/cwlp_pkg.sv =====
// Package for the channel width line parser.
// Holds payload structs, sizing constants, register indexes and character codes.
// No dependencies.
package cwlp_pkg;

  localparam int NUM_CHANNELS = 8;
  localparam int LINE_MAX     = 64;

  localparam int LINE_LEN_W = $clog2(LINE_MAX);
  localparam int CH_LIMIT   = (NUM_CHANNELS < 8) ? NUM_CHANNELS : 8;
  localparam int ACC_W      = 17;
  localparam int ACC_MAX    = 131071;
  localparam int FLEN_W     = 7;
  localparam int FLEN_MAX   = 127;
  localparam int WIDTH_MIN_LEN = 3;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [1:0] REG_CHANNEL_MASK = 2'd0;
  localparam logic [1:0] REG_MIN_WIDTH    = 2'd1;
  localparam logic [1:0] REG_MAX_WIDTH    = 2'd2;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic [15:0] MIN_WIDTH_RST = 16'd750;
  localparam logic [15:0] MAX_WIDTH_RST = 16'd2250;

  typedef enum logic [1:0] {
    PH_SKIP,
    PH_DIGITS,
    PH_DONE
  } conv_phase_t;

  typedef struct packed {
    logic [7:0]  rx_byte;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  channel_index;
    logic [15:0] pulse_width;
    logic [31:0] stamp_ms;
  } out_item_t;

endpackage

// ===== sv/channel_width_line_parser_top.sv =====
// Channel width line parser top level: byte stream in, parsed channel/width items out.
// Depends on cwlp_pkg.
//
//  Channel | Handshake                 | Payload
//  in_     | in_valid / in_ready       | in_item  (rx_byte, now_ms)
//  out_    | out_valid / out_ready     | out_item (channel_index, pulse_width, stamp_ms)
//  cfg     | psel/penable/pwrite/pready| paddr, pwdata, prdata
//
// One byte is taken every cycle while in_ready is high; the parse state updates in the cycle the byte is taken.
// A result appears in the cycle after its newline is taken, held in a single output register.
// in_ready drops only while that register holds an item the sink has not taken.
// Reset (rst_n low, synchronous) clears the parse state and loads register defaults.
module channel_width_line_parser_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  cwlp_pkg::in_item_t          in_item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output cwlp_pkg::out_item_t         out_item,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cwlp_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [cwlp_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [cwlp_pkg::CFG_DATA_W-1:0] prdata,
  output logic                        pready
);
  import cwlp_pkg::*;

  logic [7:0]  mask_r;
  logic [15:0] min_width_r;
  logic [15:0] max_width_r;

  logic [LINE_LEN_W-1:0] line_length_r, line_length_nxt;
  logic                  too_long_r, too_long_nxt;
  logic                  in_width_r, in_width_nxt;
  logic [FLEN_W-1:0]     field_length_r, field_length_nxt;
  logic                  nul_seen_r, nul_seen_nxt;
  conv_phase_t           phase_r, phase_nxt;
  logic                  negative_r, negative_nxt;
  logic [ACC_W-1:0]      accum_r, accum_nxt;
  logic [ACC_W-1:0]      saved_ch_r, saved_ch_nxt;
  logic                  saved_ok_r, saved_ok_nxt;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r, out_item_nxt;

  logic      in_acc;
  logic      cfg_wr;
  logic [7:0] b;
  logic       is_digit;
  logic       is_space;
  logic [3:0] digit;
  logic [ACC_W+3:0] acc_sum;
  logic [ACC_W-1:0] acc_sat;
  logic       line_ok;
  logic       emit;

  assign pready   = 1'b1;
  assign cfg_wr   = psel & penable & pwrite;
  assign in_ready = ~out_valid_r | out_ready;
  assign in_acc   = in_valid & in_ready;
  assign b        = in_item.rx_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      min_width_r <= MIN_WIDTH_RST;
      max_width_r <= MAX_WIDTH_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_CHANNEL_MASK: mask_r      <= pwdata[7:0];
        REG_MIN_WIDTH:    min_width_r <= pwdata[15:0];
        REG_MAX_WIDTH:    max_width_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_CHANNEL_MASK: prdata = {24'd0, mask_r};
      REG_MIN_WIDTH:    prdata = {16'd0, min_width_r};
      REG_MAX_WIDTH:    prdata = {16'd0, max_width_r};
      default:          prdata = '0;
    endcase
  end

  always_comb begin
    is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
    is_space = ((b >= 8'd9) && (b <= 8'd13)) || (b == CHAR_SPACE);
    digit    = 4'(b - CHAR_ZERO);
    acc_sum  = ({4'd0, accum_r} << 3) + ({4'd0, accum_r} << 1) + {17'd0, digit};
    acc_sat  = (acc_sum > (ACC_W+4)'(ACC_MAX)) ? ACC_W'(ACC_MAX) : acc_sum[ACC_W-1:0];

    line_ok = ~too_long_r & in_width_r & saved_ok_r
            & (field_length_r >= FLEN_W'(WIDTH_MIN_LEN))
            & ~(negative_r & (accum_r != '0));
    emit = line_ok
         & (saved_ch_r < ACC_W'(CH_LIMIT))
         & mask_r[saved_ch_r[2:0]]
         & (accum_r >= {1'b0, min_width_r})
         & (accum_r <= {1'b0, max_width_r});

    line_length_nxt  = line_length_r;
    too_long_nxt     = too_long_r;
    in_width_nxt     = in_width_r;
    field_length_nxt = field_length_r;
    nul_seen_nxt     = nul_seen_r;
    phase_nxt        = phase_r;
    negative_nxt     = negative_r;
    accum_nxt        = accum_r;
    saved_ch_nxt     = saved_ch_r;
    saved_ok_nxt     = saved_ok_r;
    out_valid_nxt    = out_valid_r & ~out_ready;
    out_item_nxt     = out_item_r;

    if (in_acc) begin
      if (b == CHAR_LF) begin
        out_valid_nxt              = emit;
        out_item_nxt.channel_index = saved_ch_r[2:0];
        out_item_nxt.pulse_width   = accum_r[15:0];
        out_item_nxt.stamp_ms      = in_item.now_ms;
        line_length_nxt  = '0;
        too_long_nxt     = 1'b0;
        in_width_nxt     = 1'b0;
        saved_ch_nxt     = '0;
        saved_ok_nxt     = 1'b0;
        field_length_nxt = '0;
        nul_seen_nxt     = 1'b0;
        phase_nxt        = PH_SKIP;
        negative_nxt     = 1'b0;
        accum_nxt        = '0;
      end else if (!too_long_r) begin
        if (line_length_r == LINE_LEN_W'(LINE_MAX - 1)) begin
          too_long_nxt = 1'b1;
        end else begin
          line_length_nxt = line_length_r + 1'b1;
          if (!in_width_r && (b == CHAR_SPACE)) begin
            saved_ok_nxt     = (field_length_r != '0) & ~(negative_r & (accum_r != '0));
            saved_ch_nxt     = accum_r;
            in_width_nxt     = 1'b1;
            field_length_nxt = '0;
            nul_seen_nxt     = 1'b0;
            phase_nxt        = PH_SKIP;
            negative_nxt     = 1'b0;
            accum_nxt        = '0;
          end else begin
            if (!nul_seen_r) begin
              if (b == CHAR_NUL) begin
                nul_seen_nxt = 1'b1;
              end else if (field_length_r != FLEN_W'(FLEN_MAX)) begin
                field_length_nxt = field_length_r + 1'b1;
              end
            end
            case (phase_r)
              PH_SKIP: begin
                if (is_space) begin
                  phase_nxt = PH_SKIP;
                end else if ((b == CHAR_PLUS) || (b == CHAR_MINUS)) begin
                  negative_nxt = (b == CHAR_MINUS);
                  phase_nxt    = PH_DIGITS;
                end else if (is_digit) begin
                  accum_nxt = acc_sat;
                  phase_nxt = PH_DIGITS;
                end else begin
                  phase_nxt = PH_DONE;
                end
              end
              PH_DIGITS: begin
                if (is_digit) begin
                  accum_nxt = acc_sat;
                end else begin
                  phase_nxt = PH_DONE;
                end
              end
              default: phase_nxt = phase_r;
            endcase
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_length_r  <= '0;
      too_long_r     <= 1'b0;
      in_width_r     <= 1'b0;
      field_length_r <= '0;
      nul_seen_r     <= 1'b0;
      phase_r        <= PH_SKIP;
      negative_r     <= 1'b0;
      accum_r        <= '0;
      saved_ch_r     <= '0;
      saved_ok_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      line_length_r  <= line_length_nxt;
      too_long_r     <= too_long_nxt;
      in_width_r     <= in_width_nxt;
      field_length_r <= field_length_nxt;
      nul_seen_r     <= nul_seen_nxt;
      phase_r        <= phase_nxt;
      negative_r     <= negative_nxt;
      accum_r        <= accum_nxt;
      saved_ch_r     <= saved_ch_nxt;
      saved_ok_r     <= saved_ok_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== sv/cwlp_checker.sv =====
// Port-level checker for the channel width line parser, with its bind.
// Depends on cwlp_pkg and channel_width_line_parser_top.
module cwlp_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input cwlp_pkg::in_item_t  in_item,
  input logic                out_valid,
  input logic                out_ready,
  input cwlp_pkg::out_item_t out_item
);
  import cwlp_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  // stall input while a result waits
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while result stalled");

  // only a newline can raise a result
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_item.rx_byte != CHAR_LF) |=> !out_valid)
    else $error("result after non-newline item");

  // stamp a result with its newline time
  a_stamp: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_item.rx_byte == CHAR_LF) ##1 out_valid
    |-> out_item.stamp_ms == $past(in_item.now_ms))
    else $error("result stamp mismatch");

endmodule

bind channel_width_line_parser_top cwlp_checker u_cwlp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
